// File: rtl/mvm_pkg.sv
// ----------------------------------------------------------------------------
// mvm_pkg
// Shared types, register codes and Q16.16 arithmetic helpers for the
// matrix-vector multiply core.
// ----------------------------------------------------------------------------
package mvm_pkg;

  localparam int unsigned MaxDim    = 8;
  // Active column and line counts never exceed this cap.
  localparam int unsigned ActCap    = (MaxDim < 8) ? MaxDim : 8;
  localparam int unsigned CoefDepth = MaxDim * MaxDim;
  localparam int unsigned CoefAddrW = $clog2(CoefDepth);
  localparam int unsigned LineW     = $clog2(ActCap);

  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 4;

  localparam logic [CfgIdxW-1:0] CfgNumCols  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgNumLines = CfgIdxW'(1);

  localparam logic OpLoad   = 1'b0;
  localparam logic OpVector = 1'b1;

  typedef struct packed {
    logic               opcode;
    logic [2:0]         col_index;
    logic [2:0]         line_index;
    logic signed [31:0] data_value;
    logic               last_element;
  } mvm_req_t;

  typedef struct packed {
    logic [2:0]         out_line;
    logic signed [31:0] out_value;
    logic               out_last;
  } mvm_res_t;

  typedef enum logic [4:0] {
    StIdle    = 5'b00001,
    StMac     = 5'b00010,
    StDrain   = 5'b00100,
    StEmit    = 5'b01000,
    StEmitEnd = 5'b10000
  } mvm_state_e;

  // Clamp a count register into 1..ActCap.
  function automatic logic [CfgDataW-1:0] active_count(input logic [CfgDataW-1:0] raw);
    if (raw == '0) begin
      return CfgDataW'(1);
    end
    if (raw > CfgDataW'(ActCap)) begin
      return CfgDataW'(ActCap);
    end
    return raw;
  endfunction

  function automatic logic [CoefAddrW-1:0] coef_addr(input logic [2:0] col,
                                                     input logic [2:0] line);
    logic [CoefAddrW+3:0] addr;
    addr = (CoefAddrW+4)'(col) * (CoefAddrW+4)'(MaxDim) + (CoefAddrW+4)'(line);
    return addr[CoefAddrW-1:0];
  endfunction

  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [64:0] sum;
    sum = {a[63], a} + {b[63], b};
    if (sum[64] != sum[63]) begin
      return sum[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
    end
    return sum[63:0];
  endfunction

  // Q32.32 accumulator to saturated Q16.16.
  function automatic logic signed [31:0] to_q16(input logic signed [63:0] acc);
    if (!acc[63] && (acc[62:47] != '0)) begin
      return 32'sh7FFF_FFFF;
    end
    if (acc[63] && (acc[62:47] != '1)) begin
      return 32'sh8000_0000;
    end
    return acc[47:16];
  endfunction

endpackage

// File: rtl/mvm_ram.sv
// ----------------------------------------------------------------------------
// mvm_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mvm_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/matrix_vector_multiply_core.sv
// ----------------------------------------------------------------------------
// matrix_vector_multiply_core
// Signed Q16.16 matrix times vector engine with 64-bit saturating
// accumulators; the active lines are multiplied and accumulated in turn.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter when start is high and busy is low. A load request writes
//   one coefficient in that cycle and leaves busy low, so loads stream at one
//   per cycle. A vector request raises busy while it is worked on: one
//   line per cycle goes through read, multiply and accumulate-write on the
//   accumulator memory's single read port. A vector element whose index is
//   not below num_cols is skipped at once.
//   A request marked last then reads the accumulators out, one per cycle:
//   the first result passes the emit and result registers, and the block
//   stays busy through StEmitEnd. Each result is on result_o for
//   exactly one cycle, flagged by result_valid_o; the receiver cannot stall,
//   so results are never held. Accumulators then read as zero again.
//   The register port is always ready; write it only while busy is low.
//   Reset: num_cols and num_lines return to 8, all accumulators read as
//   zero. Coefficients are undefined until loaded.
// ----------------------------------------------------------------------------
module matrix_vector_multiply_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  mvm_pkg::mvm_req_t               req_i,
  output logic                            result_valid_o,
  output mvm_pkg::mvm_res_t               result_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [mvm_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [mvm_pkg::CfgDataW-1:0]    cfg_data_i
);
  import mvm_pkg::*;

  mvm_state_e state_q, state_d;

  logic [CfgDataW-1:0] num_cols_q, num_lines_q;
  logic [CfgDataW-1:0] ncols, nlines;
  logic [LineW-1:0]    last_line;

  logic [LineW-1:0]    cnt_q, cnt_d;
  logic [2:0]          col_q;
  logic signed [31:0]  data_q;
  logic                last_q;

  logic                accept;
  logic                mac_issue, emit_issue, clear_acc;

  logic                coef_we;
  logic [CoefAddrW-1:0] coef_waddr, coef_raddr;
  logic [31:0]         coef_rdata;
  logic signed [31:0]  coef_s;

  logic [63:0]         acc_rdata;
  logic signed [63:0]  acc_read;
  logic signed [63:0]  acc_sum;
  logic [ActCap-1:0]   acc_valid_q;

  logic                mac1_valid_q, mac2_valid_q;
  logic [LineW-1:0]    mac1_line_q, mac2_line_q;
  logic signed [63:0]  prod_d, prod_q, acc_q;

  logic                emit1_valid_q, emit1_last_q;
  logic [LineW-1:0]    emit1_line_q;

  logic                result_valid_q;
  mvm_res_t            result_q;

  assign ncols     = active_count(num_cols_q);
  assign nlines    = active_count(num_lines_q);
  assign last_line = LineW'(nlines - CfgDataW'(1));

  assign busy        = (state_q != StIdle);
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;

  // Register port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_cols_q  <= CfgDataW'(8);
      num_lines_q <= CfgDataW'(8);
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CfgNumCols) begin
        num_cols_q <= cfg_data_i;
      end else if (cfg_index_i == CfgNumLines) begin
        num_lines_q <= cfg_data_i;
      end
    end
  end

  // Sequencer
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    mac_issue  = 1'b0;
    emit_issue = 1'b0;
    clear_acc  = 1'b0;
    unique case (state_q)
      StIdle: begin
        cnt_d = '0;
        if (accept && (req_i.opcode == OpVector)) begin
          if (CfgDataW'(req_i.col_index) < ncols) begin
            state_d = StMac;
          end else if (req_i.last_element) begin
            state_d = StEmit;
          end
        end
      end
      StMac: begin
        mac_issue = 1'b1;
        if (cnt_q == last_line) begin
          state_d = StDrain;
        end else begin
          cnt_d = cnt_q + LineW'(1);
        end
      end
      StDrain: begin
        cnt_d = '0;
        // wait for the last accumulate write to land
        if (!mac1_valid_q && !mac2_valid_q) begin
          state_d = last_q ? StEmit : StIdle;
        end
      end
      StEmit: begin
        emit_issue = 1'b1;
        if (cnt_q == last_line) begin
          state_d = StEmitEnd;
        end else begin
          cnt_d = cnt_q + LineW'(1);
        end
      end
      StEmitEnd: begin
        clear_acc = 1'b1;
        state_d   = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Hold the vector request while it is worked on
  always_ff @(posedge clk_i) begin
    if (accept && (req_i.opcode == OpVector)) begin
      col_q  <= req_i.col_index;
      data_q <= req_i.data_value;
      last_q <= req_i.last_element;
    end
  end

  // Coefficient memory
  assign coef_we = accept && (req_i.opcode == OpLoad) &&
                   (32'(req_i.col_index) < MaxDim) && (32'(req_i.line_index) < MaxDim);
  assign coef_waddr = coef_addr(req_i.col_index, req_i.line_index);
  assign coef_raddr = coef_addr(col_q, 3'(cnt_q));

  mvm_ram #(
    .Width (32),
    .Depth (CoefDepth)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (coef_we),
    .waddr_i (coef_waddr),
    .wdata_i (req_i.data_value),
    .raddr_i (coef_raddr),
    .rdata_o (coef_rdata)
  );

  assign coef_s = coef_rdata;

  // Accumulator memory; an entry without its valid bit reads as zero
  assign acc_sum = sat_add64(acc_q, prod_q);

  mvm_ram #(
    .Width (64),
    .Depth (ActCap)
  ) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (mac2_valid_q),
    .waddr_i (mac2_line_q),
    .wdata_i (acc_sum),
    .raddr_i (cnt_q),
    .rdata_o (acc_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_valid_q <= '0;
    end else if (clear_acc) begin
      acc_valid_q <= '0;
    end else if (mac2_valid_q) begin
      acc_valid_q[mac2_line_q] <= 1'b1;
    end
  end

  // Multiply-accumulate pipeline: read, multiply, add and write back
  always_comb begin
    if (mac1_valid_q) begin
      acc_read = acc_valid_q[mac1_line_q] ? signed'(acc_rdata) : 64'sd0;
    end else begin
      acc_read = acc_valid_q[emit1_line_q] ? signed'(acc_rdata) : 64'sd0;
    end
  end

  assign prod_d = data_q * coef_s;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mac1_valid_q  <= 1'b0;
      mac2_valid_q  <= 1'b0;
      emit1_valid_q <= 1'b0;
    end else begin
      mac1_valid_q  <= mac_issue;
      mac2_valid_q  <= mac1_valid_q;
      emit1_valid_q <= emit_issue;
    end
  end

  always_ff @(posedge clk_i) begin
    mac1_line_q  <= cnt_q;
    mac2_line_q  <= mac1_line_q;
    prod_q       <= prod_d;
    acc_q        <= acc_read;
    emit1_line_q <= cnt_q;
    emit1_last_q <= (cnt_q == last_line);
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= emit1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit1_valid_q) begin
      result_q.out_line  <= 3'(emit1_line_q);
      result_q.out_value <= to_q16(acc_read);
      result_q.out_last  <= emit1_last_q;
    end
  end

  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

endmodule

// File: sim/matrix_vector_multiply_core_tb.sv
// ----------------------------------------------------------------------------
// matrix_vector_multiply_core_tb
// Self-checking bench for the Q16.16 matrix-vector core. Fills the whole
// coefficient store, then drives directed corner cases, a sweep of column
// and line counts, and random vector traffic at three request-idle levels.
// A scoreboard predicts every result and checks it field by field.
// ----------------------------------------------------------------------------
module matrix_vector_multiply_core_tb;
  import mvm_pkg::*;

  localparam int unsigned SettleCycles = 16;
  localparam longint      QLimit       = 64'sh0000_8000_0000_0000;
  localparam logic [CfgIdxW-1:0] CfgSpareLow  = CfgNumLines + 1'b1;
  localparam logic [CfgIdxW-1:0] CfgSpareHigh = '1;
  localparam logic signed [31:0] QMax = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] QMin = 32'sh8000_0000;
  localparam logic signed [31:0] QOne = 32'sh0001_0000;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                start       = 1'b0;
  logic                busy;
  mvm_req_t            req         = '0;
  logic                result_valid_o;
  mvm_res_t            result_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;

  // Bench copy of the block state.
  logic signed [31:0]  coef_image [CoefDepth];
  longint              acc_image [MaxDim] = '{default: 0};
  logic [CfgDataW-1:0] cols_reg  = CfgDataW'(8);
  logic [CfgDataW-1:0] lines_reg = CfgDataW'(8);
  mvm_res_t            expected_results[$];

  int unsigned idle_pct    = 0;
  int unsigned phase_items = 0;
  int unsigned n_loads     = 0;
  int unsigned n_vectors   = 0;
  int unsigned n_results   = 0;
  int unsigned n_cfg       = 0;
  int unsigned mismatches  = 0;

  matrix_vector_multiply_core i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_i          (req),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  function automatic int unsigned span_of(logic [CfgDataW-1:0] raw, int unsigned cap);
    if (raw == '0) return 1;
    if (raw > cap) return cap;
    return raw;
  endfunction

  function automatic longint sat_sum(longint a, longint b);
    longint s;
    s = a + b;
    // Same-sign operands with a flipped sign bit mean overflow.
    if (a[63] == b[63] && s[63] != a[63]) begin
      s = a[63] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
    end
    return s;
  endfunction

  function automatic logic signed [31:0] to_fixed(longint acc);
    if (acc >= QLimit) return QMax;
    if (acc < -QLimit) return QMin;
    return acc[47:16];
  endfunction

  function automatic void apply_request(mvm_req_t r);
    int unsigned ncols;
    int unsigned nlines;
    longint      prod;
    mvm_res_t    res;
    if (r.opcode == OpLoad) begin
      coef_image[int'(r.col_index) * MaxDim + int'(r.line_index)] = r.data_value;
      return;
    end
    ncols  = span_of(cols_reg, MaxDim);
    nlines = span_of(lines_reg, ActCap);
    if (r.col_index < ncols) begin
      for (int i = 0; i < nlines; i++) begin
        prod = longint'($signed(r.data_value)) *
               longint'(coef_image[int'(r.col_index) * MaxDim + i]);
        acc_image[i] = sat_sum(acc_image[i], prod);
      end
    end
    if (!r.last_element) return;
    for (int i = 0; i < nlines; i++) begin
      res.out_line  = 3'(i);
      res.out_value = to_fixed(acc_image[i]);
      res.out_last  = (i == nlines - 1);
      expected_results.push_back(res);
    end
    foreach (acc_image[i]) acc_image[i] = 0;
  endfunction

  function automatic mvm_req_t make_request(logic op, logic [2:0] col, logic [2:0] line,
                                            logic signed [31:0] data, logic last);
    mvm_req_t r;
    r.opcode       = op;
    r.col_index    = col;
    r.line_index   = line;
    r.data_value   = data;
    r.last_element = last;
    return r;
  endfunction

  // Mostly small values keep results out of saturation; the rest hit corners or span the full range.
  function automatic logic signed [31:0] random_q16(int unsigned extreme_pct,
                                                    int unsigned wide_pct);
    int unsigned        roll;
    logic signed [31:0] v;
    roll = $urandom_range(99);
    if (roll < extreme_pct) begin
      case ($urandom_range(4))
        0:       return QMax;
        1:       return QMin;
        2:       return '0;
        3:       return '1;
        default: return QOne;
      endcase
    end
    if (roll < extreme_pct + wide_pct) return $urandom;
    v = $urandom_range(1048575);
    return v - 32'sd524288;
  endfunction

  function automatic logic [CfgDataW-1:0] random_count();
    case ($urandom_range(4))
      0:       return CfgDataW'(1);
      1:       return CfgDataW'(8);
      2:       return '0;
      3:       return '1;
      default: return CfgDataW'($urandom_range(15));
    endcase
  endfunction

  task automatic send_request(input mvm_req_t r);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
    @(negedge clk_i);
    start <= 1'b1;
    req   <= r;
    do @(posedge clk_i); while (busy);
    apply_request(r);
    if (r.opcode == OpLoad) n_loads++;
    else n_vectors++;
    phase_items++;
  endtask

  task automatic wait_results_drained();
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic pause_until_drained();
    @(negedge clk_i);
    start <= 1'b0;
    wait_results_drained();
  endtask

  // Hold requests off until the core has gone quiet.
  task automatic settle();
    pause_until_drained();
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CfgNumCols) cols_reg = data;
    else if (idx == CfgNumLines) lines_reg = data;
    n_cfg++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic load_matrix();
    for (int c = 0; c < MaxDim; c++) begin
      for (int l = 0; l < MaxDim; l++) begin
        send_request(make_request(OpLoad, 3'(c), 3'(l), random_q16(2, 0), 1'($urandom)));
      end
    end
  endtask

  // One well-formed vector: every active column once, in random order, with an occasional load between elements.
  task automatic send_vector();
    int unsigned ncols;
    int          order [MaxDim];
    int          k;
    int          tmp;
    ncols = span_of(cols_reg, MaxDim);
    for (int j = 0; j < ncols; j++) order[j] = j;
    for (int j = ncols - 1; j > 0; j--) begin
      k        = $urandom_range(j);
      tmp      = order[j];
      order[j] = order[k];
      order[k] = tmp;
    end
    for (int j = 0; j < ncols; j++) begin
      if ($urandom_range(99) < 12) begin
        send_request(make_request(OpLoad, 3'($urandom), 3'($urandom), random_q16(3, 0),
                                  1'($urandom)));
      end
      send_request(make_request(OpVector, 3'(order[j]), 3'($urandom), random_q16(8, 10),
                                j == ncols - 1));
    end
  endtask

  task automatic test_reset_defaults();
    load_matrix();
    send_vector();
  endtask

  task automatic test_extremes();
    send_request(make_request(OpLoad, 3'd0, 3'd0, QMax, 1'b0));
    send_request(make_request(OpLoad, 3'd0, 3'd1, QMin, 1'b1));
    send_request(make_request(OpLoad, 3'd0, 3'd2, '0, 1'b0));
    send_request(make_request(OpLoad, 3'd7, 3'd7, QMin, 1'b1));
    // Drive line 0 into negative and line 1 into positive accumulator saturation.
    repeat (3) send_request(make_request(OpVector, 3'd0, 3'd7, QMin, 1'b0));
    send_request(make_request(OpVector, 3'd7, 3'd0, QMax, 1'b1));
    // Accumulators must read back as zero after a flush.
    send_request(make_request(OpVector, 3'd5, 3'd7, '0, 1'b1));
    send_request(make_request(OpVector, 3'd0, 3'd0, QOne, 1'b1));
    send_request(make_request(OpVector, 3'd0, 3'd7, '1, 1'b1));
    send_request(make_request(OpLoad, 3'd0, 3'd0, random_q16(0, 0), 1'b0));
    send_request(make_request(OpLoad, 3'd0, 3'd1, random_q16(0, 0), 1'b0));
    send_request(make_request(OpLoad, 3'd7, 3'd7, random_q16(0, 0), 1'b0));
  endtask

  task automatic test_register_sweep();
    logic [CfgDataW-1:0] col_set  [5] = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3};
    logic [CfgDataW-1:0] line_set [5] = '{4'd1, 4'd8, 4'd15, 4'd0, 4'd6};
    int unsigned         ncols;
    for (int k = 0; k < 5; k++) begin
      settle();
      cfg_write(CfgNumCols, col_set[k]);
      cfg_write(CfgNumLines, line_set[k]);
      ncols = span_of(cols_reg, MaxDim);
      // Columns at or beyond the active count must not accumulate.
      if (ncols < MaxDim) begin
        send_request(make_request(OpVector, 3'($urandom_range(MaxDim - 1, ncols)),
                                  3'($urandom), QMax, 1'b0));
      end
      send_vector();
      if (ncols < MaxDim) begin
        send_request(make_request(OpVector, 3'(MaxDim - 1), 3'($urandom), QMin, 1'b1));
      end
    end
    settle();
    cfg_write(CfgSpareLow, CfgDataW'($urandom));
    cfg_write(CfgSpareHigh, CfgDataW'($urandom));
    send_vector();
  endtask

  task automatic test_random_traffic(input int unsigned pct, input int unsigned quota);
    int unsigned roll;
    bit          paused;
    idle_pct = pct;
    settle();
    cfg_write(CfgNumCols, random_count());
    cfg_write(CfgNumLines, random_count());
    phase_items = 0;
    paused      = 1'b0;
    while (phase_items < quota) begin
      roll = $urandom_range(99);
      if (roll < 60) begin
        send_vector();
      end else if (roll < 74) begin
        send_request(make_request(OpLoad, 3'($urandom), 3'($urandom), random_q16(3, 0),
                                  1'($urandom)));
      end else if (roll < 90) begin
        send_request(make_request(OpVector, 3'($urandom), 3'($urandom), random_q16(10, 30),
                                  $urandom_range(99) < 30));
      end else if (roll < 95) begin
        settle();
        if ($urandom_range(1)) cfg_write(CfgNumCols, random_count());
        else cfg_write(CfgNumLines, random_count());
      end else begin
        pause_until_drained();
      end
      if (!paused && phase_items >= quota / 2) begin
        pause_until_drained();
        paused = 1'b1;
      end
    end
  endtask

  always @(posedge clk_i) begin
    mvm_res_t want;
    if (rst_ni && result_valid_o) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: out_line %0d out_value %0d out_last %0d",
               result_o.out_line, result_o.out_value, result_o.out_last);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        n_results++;
        if (result_o.out_line !== want.out_line) begin
          $error("out_line: expected %0d, got %0d", want.out_line, result_o.out_line);
          mismatches++;
        end
        if (result_o.out_value !== want.out_value) begin
          $error("out_value: expected %0d, got %0d", want.out_value, result_o.out_value);
          mismatches++;
        end
        if (result_o.out_last !== want.out_last) begin
          $error("out_last: expected %0d, got %0d", want.out_last, result_o.out_last);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #4_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_defaults();
    test_extremes();
    test_register_sweep();
    test_random_traffic(36, 120);
    test_random_traffic(55, 120);
    test_random_traffic(0, 120);
    pause_until_drained();
    repeat (SettleCycles) @(posedge clk_i);
    $display("Covered %0d coefficient loads, %0d vector elements, %0d results checked.",
             n_loads, n_vectors, n_results);
    $display("Count registers written %0d times; request idle at 36, 55 and 0 percent.",
             n_cfg);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: matrix_vector_multiply_core.f
rtl/mvm_pkg.sv
rtl/mvm_ram.sv
rtl/matrix_vector_multiply_core.sv
sim/matrix_vector_multiply_core_tb.sv
